// ----- sv/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator: field widths,
// operation codes, register indexes and the token that moves along the chain.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int AMT_W = 16;
    localparam int IDX_W = 4;
    localparam int CFG_W = 5;

    // Reset value of the blocks_in_use register.
    localparam logic [CFG_W-1:0] CFG_BLOCKS_RESET = 5'd16;

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    // Register indexes.
    localparam logic REG_BLOCKS_IN_USE = 1'b0;

    // One item as it travels from cell to cell.
    typedef struct packed {
        logic             valid;
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [AMT_W-1:0] amt;
        logic             last;
        logic             granted;
        logic [IDX_W-1:0] chosen;
    } t_token;

endpackage

// ----- sv/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// One block of the allocator chain. Holds the remaining capacity of its block,
// applies loads addressed to it, grants a request that fits when no earlier
// cell has granted it and the block is in use, and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module ffba_cell
    import ffba_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int CELL_ID   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [CFG_W-1:0] i_blocks_in_use,
    input  t_token           i_tok,
    output t_token           o_tok
);

    localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
    // Only the first 2**IDX_W cells can be addressed by a load.
    localparam bit               MATCHABLE = (CELL_ID < (1 << IDX_W));
    localparam logic [IDX_W-1:0] CELL_IDX  = IDX_W'(CELL_ID);

    logic [SIZE_BITS-1:0] r_rem, n_rem;
    t_token               r_tok, n_tok;
    logic [CMP_W-1:0]     w_rem_x, w_amt_x;
    logic                 w_active;

    assign w_rem_x  = CMP_W'(r_rem);
    assign w_amt_x  = CMP_W'(i_tok.amt);
    assign w_active = (int'(i_blocks_in_use) > CELL_ID);

    // Load or allocate against this block.
    always_comb begin
        n_rem = r_rem;
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (i_tok.op == OP_LOAD) begin
                if (MATCHABLE && (i_tok.idx == CELL_IDX)) begin
                    n_rem = SIZE_BITS'(i_tok.amt);
                end
            end else if (!i_tok.granted && w_active && (w_rem_x >= w_amt_x)) begin
                n_rem         = SIZE_BITS'(w_rem_x - w_amt_x);
                n_tok.granted = 1'b1;
                n_tok.chosen  = CELL_IDX;
            end
        end
    end

    // Capacity and token registers; the whole chain moves together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_rem <= n_rem;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- sv/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a row of block cells, with a stream input, a
// stream output and a register port for the search count.
// ----------------------------------------------------------------------------
// Every item, load or request, walks through a chain of NUM_BLOCKS cells, one
// cell per cycle while the chain advances, and a request's result is then
// registered in the output register; a new item is taken every cycle while
// the output side keeps accepting. The chain length sets the latency; the
// single output register sets the stall behavior: when its result is not
// taken, the whole chain holds. Loads produce no result. blocks_in_use may
// only be written while no item is in the chain.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [3:0] block_index, [19:4] amount, rest zero
    input  logic        i_s_tuser,   // [0] op
    input  logic        i_s_tlast,   // last_in_batch
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [3:0] chosen_block, rest zero
    output logic        o_m_tuser,   // [0] granted
    output logic        o_m_tlast,   // batch_done
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_token             w_tok [0:NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] w_valid;
    logic               w_adv;
    logic [CFG_W-1:0]   r_blocks_in_use;
    logic               r_out_valid;
    logic               r_granted;
    logic [IDX_W-1:0]   r_chosen;
    logic               r_last;

    // Register port: one register, always ready.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= CFG_BLOCKS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BLOCKS_IN_USE)) begin
            r_blocks_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? 32'(r_blocks_in_use) : 32'd0;

    // The chain moves whenever the output register can take a new result.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    // Token entering the first cell.
    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].valid   = i_s_tvalid;
        w_tok[0].op      = i_s_tuser;
        w_tok[0].idx     = i_s_tdata[3:0];
        w_tok[0].amt     = i_s_tdata[19:4];
        w_tok[0].last    = i_s_tlast;
    end

    // Chain of block cells.
    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        ffba_cell #(
            .SIZE_BITS (SIZE_BITS),
            .CELL_ID   (k)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_adv           (w_adv),
            .i_blocks_in_use (r_blocks_in_use),
            .i_tok           (w_tok[k]),
            .o_tok           (w_tok[k+1])
        );
        assign w_valid[k] = w_tok[k+1].valid;
    end

    // Output register: only requests leave the chain as results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok[NUM_BLOCKS].valid && (w_tok[NUM_BLOCKS].op == OP_REQ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_granted <= w_tok[NUM_BLOCKS].granted;
            r_chosen  <= w_tok[NUM_BLOCKS].chosen;
            r_last    <= w_tok[NUM_BLOCKS].last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_chosen};
    assign o_m_tuser  = r_granted;
    assign o_m_tlast  = r_last;

    // A refused request always reports block zero.
    a_refused_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 8'd0))
        else $error("refused request reports a nonzero block");

    // A stalled output freezes the occupancy of the whole chain.
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (w_valid == $past(w_valid)))
        else $error("chain moved while the output was stalled");

    // An accepted item occupies the first cell on the next cycle.
    a_enter_chain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> w_valid[0])
        else $error("accepted item did not enter the chain");

endmodule
